[sv/format_string_number_printer_macros.svh]
// Assertion macros shared by the format string number printer RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef FORMAT_STRING_NUMBER_PRINTER_MACROS_SVH
`define FORMAT_STRING_NUMBER_PRINTER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define FSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define FSP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/fsp_pkg.sv]
// Package of the format string number printer: state type, character codes
// and the digit-to-ASCII function. No dependencies.
package fsp_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } fsp_state_e;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChLowerX  = 8'h78;
  localparam logic [7:0] ChUpperX  = 8'h58;
  localparam logic [7:0] ChLowerD  = 8'h64;
  localparam logic [7:0] ChLowerI  = 8'h69;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChUpperA  = 8'h41;

  localparam int unsigned ValueW   = 16;
  localparam int unsigned DigitReg = 20;   // five BCD digits or four hex digits
  localparam logic [2:0]  HexDigits = 3'd4;
  localparam logic [2:0]  DecDigits = 3'd5;

  // Maps one digit (0..15) to its upper-case ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ChZero + {4'd0, d};
    end else begin
      c = ChUpperA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

[sv/format_string_number_printer.sv]
// Format string number printer: top level, a digit-serial converter and printer.
// Depends on fsp_pkg and format_string_number_printer_macros.svh.
//
// The block takes one format character per input transfer, together with the 16-bit value
// that a directive would print, and sends ASCII characters out one transfer at a time.
// An ordinary character is echoed in a single output transfer with tlast set. A '%' sends
// nothing and arms a directive flag; the next character disarms it. After '%', 'x' or 'X'
// prints the value in upper-case hex, 'd' or 'i' prints it in decimal, in both cases with
// leading zeros suppressed and zero printed as a single '0'; any other character is
// dropped. tlast marks the final character caused by each input transfer.
// Sequence: a hex directive is loaded into the digit register, then shifts out four digit
// positions, one nibble per cycle while the output register is free. A decimal directive
// first runs a bit-serial binary-to-BCD conversion (shift and add three) over the 16 value
// bits, then shifts out five digit positions, one per cycle while the output register is
// free. Suppressed leading zeros still take their shift step, and shifting waits while the
// output side stalls. The output character sits in a register, so the next input is taken
// once that register is empty, or at the same edge at which its last character is
// transferred; while that character waits, the input is held off.
`include "format_string_number_printer_macros.svh"

module format_string_number_printer import fsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] fmt_char, [23:8] value
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_char
  output logic        m_axis_tlast    // last
);

  fsp_state_e state_q, state_d;

  // Directive flag: a '%' was the previous character.
  logic after_pct_q, after_pct_d;

  // Digit shift register; the most significant digit sits in the top nibble.
  logic [DigitReg-1:0] dig_q, dig_d;
  // Binary shift register that feeds the BCD converter one bit per cycle.
  logic [ValueW-1:0]   bin_q, bin_d;
  logic [3:0]          bit_cnt_q, bit_cnt_d;
  // Digit positions still to be shifted out.
  logic [2:0]          cnt_q, cnt_d;
  // A nonzero digit has been printed, so zeros are no longer leading.
  logic                shown_q, shown_d;

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;

  logic       out_free;
  logic       out_load;
  logic       in_xfer;
  logic [7:0] fmt_char;
  logic [ValueW-1:0] value;
  logic [DigitReg-1:0] bcd_adj;
  logic [3:0] top_digit;
  logic       last_pos;

  assign fmt_char = s_axis_tdata[7:0];
  assign value    = s_axis_tdata[23:8];

  // The output register can take a new character when empty or being drained.
  assign out_free  = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_xfer   = s_axis_tvalid && s_axis_tready;

  assign top_digit = dig_q[DigitReg-1 -: 4];
  assign last_pos  = (cnt_q == 3'd1);

  // Add three to every BCD digit of five or more before the next left shift.
  always_comb begin
    for (int i = 0; i < DigitReg / 4; i++) begin
      if (dig_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = dig_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = dig_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    after_pct_d = after_pct_q;
    dig_d       = dig_q;
    bin_d       = bin_q;
    bit_cnt_d   = bit_cnt_q;
    cnt_d       = cnt_q;
    shown_d     = shown_q;
    out_load    = 1'b0;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          priority if (after_pct_q) begin
            after_pct_d = 1'b0;
            shown_d     = 1'b0;
            if (fmt_char == ChLowerX || fmt_char == ChUpperX) begin
              dig_d   = {value, 4'h0};
              cnt_d   = HexDigits;
              state_d = ST_EMIT;
            end else if (fmt_char == ChLowerD || fmt_char == ChLowerI) begin
              dig_d     = '0;
              bin_d     = value;
              bit_cnt_d = '0;
              state_d   = ST_CONV;
            end
          end else if (fmt_char == ChPercent) begin
            after_pct_d = 1'b1;
          end else begin
            out_load   = 1'b1;
            out_char_d = fmt_char;
            out_last_d = 1'b1;
          end
        end
      end
      ST_CONV: begin
        dig_d     = {bcd_adj[DigitReg-2:0], bin_q[ValueW-1]};
        bin_d     = {bin_q[ValueW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 4'd1;
        if (bit_cnt_q == 4'd15) begin
          cnt_d   = DecDigits;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          dig_d = {dig_q[DigitReg-5:0], 4'h0};
          cnt_d = cnt_q - 3'd1;
          if (top_digit != 4'h0 || shown_q || last_pos) begin
            shown_d    = 1'b1;
            out_load   = 1'b1;
            out_char_d = digit_char(top_digit);
            out_last_d = last_pos;
          end
          if (last_pos) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      after_pct_q <= 1'b0;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      cnt_q       <= '0;
      shown_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      after_pct_q <= after_pct_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      cnt_q       <= cnt_d;
      shown_q     <= shown_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q      <= dig_d;
    bin_q      <= bin_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

  // No input is taken while a directive is being converted or printed.
  `FSP_ASSERT_IMP(a_busy_no_input, state_q != ST_IDLE, !s_axis_tready)
  // The converter never drives the output register.
  `FSP_ASSERT_IMP(a_conv_no_output, state_q == ST_CONV, !out_load)
  // Loading the final character of an item always returns to idle.
  `FSP_ASSERT_NXT(a_last_to_idle, out_load && out_last_d, state_q == ST_IDLE)

endmodule
